// ----- src/dtsp_pkg.sv -----
// constants shared by the date-time string parser
package dtsp_pkg;

  localparam int unsigned POS_W = 5;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DAY_ACC_W = 6;
  localparam int unsigned MINUTE_ACC_W = 7;

  localparam logic [POS_W-1:0] STR_LEN = 5'd16;
  localparam logic [POS_W-1:0] POS_SAT = 5'd17;

  // byte positions inside "YYYY-MM-DD/HH:MM"
  localparam logic [POS_W-1:0] POS_YEAR0 = 5'd0;
  localparam logic [POS_W-1:0] POS_YEAR1 = 5'd1;
  localparam logic [POS_W-1:0] POS_YEAR2 = 5'd2;
  localparam logic [POS_W-1:0] POS_YEAR3 = 5'd3;
  localparam logic [POS_W-1:0] POS_DASH0 = 5'd4;
  localparam logic [POS_W-1:0] POS_MON0 = 5'd5;
  localparam logic [POS_W-1:0] POS_MON1 = 5'd6;
  localparam logic [POS_W-1:0] POS_DASH1 = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY0 = 5'd8;
  localparam logic [POS_W-1:0] POS_DAY1 = 5'd9;
  localparam logic [POS_W-1:0] POS_SLASH = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR0 = 5'd11;
  localparam logic [POS_W-1:0] POS_HOUR1 = 5'd12;
  localparam logic [POS_W-1:0] POS_COLON = 5'd13;
  localparam logic [POS_W-1:0] POS_MIN0 = 5'd14;
  localparam logic [POS_W-1:0] POS_MIN1 = 5'd15;

  // characters
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX = 8'h36;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // month numbers and limits
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [4:0] MONTH_MAX = 5'd12;

  localparam logic [DAY_ACC_W-1:0] DAYS_LONG = 6'd31;
  localparam logic [DAY_ACC_W-1:0] DAYS_SHORT = 6'd30;
  localparam logic [DAY_ACC_W-1:0] DAYS_FEB_LEAP = 6'd29;
  localparam logic [DAY_ACC_W-1:0] DAYS_FEB = 6'd28;

  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MINUTE_ACC_W-1:0] MINUTE_MAX = 7'd59;

endpackage

// ----- src/datetime_string_parser.sv -----
// date-time string parser: streaming check and decode of "YYYY-MM-DD/HH:MM"
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   byte    | byte_valid, byte_stall | char_in, is_last
//   result  | res_valid, res_stall   | valid_res, year, month, day, hour, minute
//
// one byte per cycle while byte_stall is low; a byte is held in the input register
// and is folded into the accumulators when it leaves it, and the result register
// is loaded on the edge at which its last byte leaves the input register
// a last byte waits in the input register while an earlier result is stalled
// synchronous active-high reset clears position, error flag, accumulators and
// both valid flags
module datetime_string_parser
  import dtsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [7:0]          char_in,
  input  logic                is_last,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                valid_res,
  output logic [YEAR_W-1:0]   year,
  output logic [MONTH_W-1:0]  month,
  output logic [DAY_W-1:0]    day,
  output logic [HOUR_W-1:0]   hour,
  output logic [MINUTE_W-1:0] minute
);

  // input register
  logic       q_valid;
  logic [7:0] q_char;
  logic       q_last;

  // parse state
  logic [POS_W-1:0]        pos;
  logic                    err;
  logic [YEAR_W-1:0]       year_acc;
  logic [MONTH_W-1:0]      month_acc;
  logic [DAY_ACC_W-1:0]    day_acc;
  logic [HOUR_W-1:0]       hour_acc;
  logic [MINUTE_ACC_W-1:0] minute_acc;

  // leap-year tracking, built digit by digit so no mod 100 or mod 400 is needed
  logic hi_div4;   // first two year digits divisible by 4
  logic d2_odd;    // third year digit odd
  logic d2_zero;   // third year digit zero
  logic leap;

  logic [POS_W-1:0]        pos_next;
  logic                    err_next;
  logic [YEAR_W-1:0]       year_next;
  logic [MONTH_W-1:0]      month_next;
  logic [DAY_ACC_W-1:0]    day_next;
  logic [HOUR_W-1:0]       hour_next;
  logic [MINUTE_ACC_W-1:0] minute_next;
  logic                    hi_div4_next;
  logic                    d2_odd_next;
  logic                    d2_zero_next;
  logic                    leap_next;

  logic       fire;
  logic       is_digit;
  logic [3:0] dval;
  logic       lead_ok;
  logic [7:0] lead_hi;

  logic [17:0] year_x10;
  logic [6:0]  month_x10;
  logic [9:0]  day_x10;
  logic [8:0]  hour_x10;
  logic [10:0] minute_x10;
  logic [1:0]  hi_mod4;
  logic [1:0]  lo_mod4;

  logic [DAY_ACC_W-1:0] day_limit;
  logic                 legal;
  logic                 ok;

  // a waiting last byte is the only item that must hold for the result slot
  assign byte_stall = q_valid && q_last && res_valid && res_stall;
  assign fire       = q_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      q_char <= char_in;
      q_last <= is_last;
    end
  end

  // highest allowed leading digit of each two-digit field
  always_comb begin
    case (pos)
      POS_MON0:  lead_hi = CH_ONE;
      POS_DAY0:  lead_hi = CH_THREE;
      POS_HOUR0: lead_hi = CH_TWO;
      POS_MIN0:  lead_hi = CH_SIX;
      default:   lead_hi = CH_NINE;
    endcase
  end

  // digit decode of the registered byte
  assign is_digit = (q_char >= CH_ZERO) && (q_char <= CH_NINE);
  assign dval     = q_char[3:0];
  assign lead_ok  = (q_char >= CH_ZERO) && (q_char <= lead_hi);

  // times ten as shift and add
  assign year_x10   = ({4'd0, year_acc} << 3) + ({4'd0, year_acc} << 1) + {14'd0, dval};
  assign month_x10  = ({3'd0, month_acc} << 3) + ({3'd0, month_acc} << 1) + {3'd0, dval};
  assign day_x10    = ({4'd0, day_acc} << 3) + ({4'd0, day_acc} << 1) + {6'd0, dval};
  assign hour_x10   = ({4'd0, hour_acc} << 3) + ({4'd0, hour_acc} << 1) + {5'd0, dval};
  assign minute_x10 = ({4'd0, minute_acc} << 3) + ({4'd0, minute_acc} << 1)
                      + {7'd0, dval};

  // (10a + b) mod 4 equals (2a + b) mod 4
  assign hi_mod4 = {year_acc[0], 1'b0} + dval[1:0];
  assign lo_mod4 = {d2_odd, 1'b0} + dval[1:0];

  always_comb begin
    err_next     = err;
    year_next    = year_acc;
    month_next   = month_acc;
    day_next     = day_acc;
    hour_next    = hour_acc;
    minute_next  = minute_acc;
    hi_div4_next = hi_div4;
    d2_odd_next  = d2_odd;
    d2_zero_next = d2_zero;
    leap_next    = leap;

    case (pos)
      POS_YEAR0: begin
        if ((q_char >= CH_ONE) && (q_char <= CH_NINE)) begin
          year_next = {10'd0, dval};
        end else begin
          err_next = 1'b1;
        end
      end
      POS_YEAR1, POS_YEAR2, POS_YEAR3: begin
        if (is_digit) begin
          year_next = year_x10[YEAR_W-1:0];
          if (pos == POS_YEAR1) begin
            hi_div4_next = (hi_mod4 == 2'd0);
          end
          if (pos == POS_YEAR2) begin
            d2_odd_next  = dval[0];
            d2_zero_next = (dval == 4'd0);
          end
          if (pos == POS_YEAR3) begin
            // century years follow the upper two digits
            leap_next = (d2_zero && dval == 4'd0) ? hi_div4 : (lo_mod4 == 2'd0);
          end
        end else begin
          err_next = 1'b1;
        end
      end
      POS_DASH0, POS_DASH1: begin
        if (q_char != CH_DASH) err_next = 1'b1;
      end
      POS_SLASH: begin
        if (q_char != CH_SLASH) err_next = 1'b1;
      end
      POS_COLON: begin
        if (q_char != CH_COLON) err_next = 1'b1;
      end
      POS_MON0: begin
        if (lead_ok) month_next = dval;
        else err_next = 1'b1;
      end
      POS_MON1: begin
        if (is_digit) begin
          month_next = month_x10[MONTH_W-1:0];
          if (month_x10 == 7'd0 || month_x10 > {2'd0, MONTH_MAX}) err_next = 1'b1;
        end else begin
          err_next = 1'b1;
        end
      end
      POS_DAY0: begin
        if (lead_ok) day_next = {2'd0, dval};
        else err_next = 1'b1;
      end
      POS_DAY1: begin
        if (is_digit) day_next = day_x10[DAY_ACC_W-1:0];
        else err_next = 1'b1;
      end
      POS_HOUR0: begin
        if (lead_ok) hour_next = {1'b0, dval};
        else err_next = 1'b1;
      end
      POS_HOUR1: begin
        if (is_digit) hour_next = hour_x10[HOUR_W-1:0];
        else err_next = 1'b1;
      end
      POS_MIN0: begin
        if (lead_ok) minute_next = {3'd0, dval};
        else err_next = 1'b1;
      end
      POS_MIN1: begin
        if (is_digit) minute_next = minute_x10[MINUTE_ACC_W-1:0];
        else err_next = 1'b1;
      end
      // too long
      default: err_next = 1'b1;
    endcase
  end

  assign pos_next = (pos < POS_SAT) ? pos + 5'd1 : pos;

  // calendar check on the values after this byte
  always_comb begin
    if (month_next == MON_FEB) begin
      day_limit = leap_next ? DAYS_FEB_LEAP : DAYS_FEB;
    end else if (month_next == MON_APR || month_next == MON_JUN ||
                 month_next == MON_SEP || month_next == MON_NOV) begin
      day_limit = DAYS_SHORT;
    end else begin
      day_limit = DAYS_LONG;
    end
  end

  assign legal = (month_next != 4'd0) && ({1'b0, month_next} <= MONTH_MAX) &&
                 (day_next != 6'd0) && (day_next <= day_limit) &&
                 (hour_next <= HOUR_MAX) && (minute_next <= MINUTE_MAX);

  assign ok = !err_next && (pos_next == STR_LEN) && legal;

  // parse state: cleared by reset and after every result
  always_ff @(posedge clk) begin
    if (rst || (fire && q_last)) begin
      pos        <= '0;
      err        <= 1'b0;
      year_acc   <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      hi_div4    <= 1'b0;
      d2_odd     <= 1'b0;
      d2_zero    <= 1'b0;
      leap       <= 1'b0;
    end else if (fire) begin
      pos        <= pos_next;
      err        <= err_next;
      year_acc   <= year_next;
      month_acc  <= month_next;
      day_acc    <= day_next;
      hour_acc   <= hour_next;
      minute_acc <= minute_next;
      hi_div4    <= hi_div4_next;
      d2_odd     <= d2_odd_next;
      d2_zero    <= d2_zero_next;
      leap       <= leap_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && q_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // fields are zeroed on any error
  always_ff @(posedge clk) begin
    if (fire && q_last) begin
      valid_res <= ok;
      year      <= ok ? year_next : '0;
      month     <= ok ? month_next : '0;
      day       <= ok ? day_next[DAY_W-1:0] : '0;
      hour      <= ok ? hour_next : '0;
      minute    <= ok ? minute_next[MINUTE_W-1:0] : '0;
    end
  end

  // a new result needs a last byte processed the cycle before
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(fire && q_last))
    else $error("result without a last byte");

  // the parser restarts after every transfer of a last byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && q_last) |=> (pos == '0 && !err))
    else $error("parse state not cleared after last byte");

  // position saturates
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_SAT)
    else $error("position past saturation");

  // an invalid result carries all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !valid_res) |->
      (year == '0 && month == '0 && day == '0 && hour == '0 && minute == '0))
    else $error("invalid result with nonzero fields");

endmodule
